// File: hw/rtl/fcd_pkg.sv
package fcd_pkg;

	// fixed field widths
	localparam int CellW   = 8;
	localparam int CfgW    = 11;
	localparam int ThreshW = 10;
	localparam int CoordW  = 10;
	localparam int NumW    = 20;
	// |gx| + |gy| tops out at 768, gx and gy alone at +/-512
	localparam int GradW   = 11;

	localparam int MinDim      = 3;
	localparam int UpperLimit  = 8;
	localparam int DimReset    = 1024;
	localparam int ThreshReset = 1;

	localparam logic [CellW-1:0] CellUnknown = 8'hFF;

	typedef enum logic [1:0] {
		REG_GRID_WIDTH      = 2'd0,
		REG_GRID_HEIGHT     = 2'd1,
		REG_LOWER_THRESHOLD = 2'd2
	} reg_index_t;

	// per-cell control that rides along the pipe
	typedef struct packed {
		logic judge;       // cell may be a frontier
		logic grid_start;  // first cell of a grid
	} item_flags_t;

	// absolute value of a signed cell; -128 comes out as 128
	function automatic logic [CellW-1:0] cell_mag(input logic [CellW-1:0] v);
		return v[CellW-1] ? CellW'(~v + 8'd1) : v;
	endfunction

endpackage

// File: hw/rtl/frontier_cell_detector.sv
// Frontier cell detector. Takes one occupancy cell per word in raster order
// (x fastest) on the s_axis side: tdata[7:0] is the signed cell value (-1 unknown,
// 0 free, up to 100 occupied), tuser[0] marks the first cell of a grid and
// clears position and frontier count. When cell (x,y) arrives, cell (x-1,y-1)
// is judged: it is a frontier if it is unknown, off the border, and the
// Sobel sum |gx|+|gy| over the neighbour magnitudes lies in
// [lower_threshold, 8]. Each frontier leaves on m_axis as one word
// {number[19:0], y[9:0], x[9:0]}, numbered in raster order from 0.
// Throughput is one cell per cycle while no skid word is held, set by the line
// store: two banks of MAX_GRID_DIM bytes, each read once and one of them written
// once per cycle at the current column. An accepted cell passes the stage 1 and
// stage 2 registers before its result is loaded into the output register. An
// output register plus one skid word decouple the sides; s_axis_tready drops
// only while the skid word is held. grid_width and grid_height are clamped to
// [3, MAX_GRID_DIM]. Write the config registers only while the block is idle.
module frontier_cell_detector #(
	parameter int MAX_GRID_DIM = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input cells
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] cell_value
	input  logic [0:0]  s_axis_tuser,   // [0] grid_start
	// frontier cells
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [9:0] frontier_x, [19:10] frontier_y,
	                                    // [39:20] frontier_number
	// config writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int XW = $clog2(MAX_GRID_DIM);
	localparam int DW = (XW + 1 > fcd_pkg::CfgW) ? XW + 1 : fcd_pkg::CfgW;
	localparam int OW = 2 * fcd_pkg::CoordW + fcd_pkg::NumW;

	// config registers
	logic [fcd_pkg::CfgW-1:0]    grid_width_q;
	logic [fcd_pkg::CfgW-1:0]    grid_height_q;
	logic [fcd_pkg::ThreshW-1:0] lower_threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q      <= fcd_pkg::CfgW'(fcd_pkg::DimReset);
			grid_height_q     <= fcd_pkg::CfgW'(fcd_pkg::DimReset);
			lower_threshold_q <= fcd_pkg::ThreshW'(fcd_pkg::ThreshReset);
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcd_pkg::REG_GRID_WIDTH:      grid_width_q      <= cfg_data;
				fcd_pkg::REG_GRID_HEIGHT:     grid_height_q     <= cfg_data;
				fcd_pkg::REG_LOWER_THRESHOLD: lower_threshold_q <= cfg_data[fcd_pkg::ThreshW-1:0];
				default: ;
			endcase
		end
	end

	// clamped size, as last index
	logic [DW-1:0] w_ext, h_ext, w_last, h_last;

	always_comb begin
		w_ext = DW'(grid_width_q);
		h_ext = DW'(grid_height_q);
		if (w_ext < DW'(fcd_pkg::MinDim)) begin
			w_last = DW'(fcd_pkg::MinDim - 1);
		end else if (w_ext > DW'(MAX_GRID_DIM)) begin
			w_last = DW'(MAX_GRID_DIM - 1);
		end else begin
			w_last = w_ext - DW'(1);
		end
		if (h_ext < DW'(fcd_pkg::MinDim)) begin
			h_last = DW'(fcd_pkg::MinDim - 1);
		end else if (h_ext > DW'(MAX_GRID_DIM)) begin
			h_last = DW'(MAX_GRID_DIM - 1);
		end else begin
			h_last = h_ext - DW'(1);
		end
	end

	// handshake: the pipe moves unless a skid word is held
	logic en, accept, skid_valid_q, out_valid_q;

	assign en            = !skid_valid_q;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	// stage 0: position of the incoming cell
	logic [XW-1:0] col_q, row_q, x_cur, y_cur;
	logic          grid_start, col_wrap, row_wrap;
	fcd_pkg::item_flags_t flags_in;

	always_comb begin
		grid_start = s_axis_tuser[0];
		x_cur      = grid_start ? '0 : col_q;
		y_cur      = grid_start ? '0 : row_q;
		col_wrap   = DW'(x_cur) >= w_last;
		row_wrap   = DW'(y_cur) >= h_last;
		flags_in.grid_start = grid_start;
		// judged cell is (x-1,y-1); its neighbourhood must stay inside
		flags_in.judge = (x_cur >= XW'(2)) && (y_cur >= XW'(2))
			&& (DW'(x_cur) <= w_last) && (DW'(y_cur) <= h_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : y_cur + XW'(1);
			end else begin
				col_q <= x_cur + XW'(1);
				row_q <= y_cur;
			end
		end
	end

	// stage 1: line store read data plus the cell itself
	logic                 valid_s1;
	logic [7:0]           cell_s1, older_s1, prev_s1;
	logic [XW-1:0]        x_s1, y_s1;
	fcd_pkg::item_flags_t flags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flags_s1 <= '0;
		end else if (en) begin
			valid_s1 <= accept;
			flags_s1 <= flags_in;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= s_axis_tdata;
			x_s1    <= x_cur;
			y_s1    <= y_cur;
		end
	end

	fcd_line_store #(
		.Depth(MAX_GRID_DIM)
	) u_line_store (
		.clk    (clk),
		.en     (accept),
		.addr   (x_cur),
		.bank   (y_cur[0]),
		.wr_data(s_axis_tdata),
		.older  (older_s1),
		.prev   (prev_s1)
	);

	// stage 2: gx, gy of the judged cell
	logic                              valid_s2;
	logic signed [fcd_pkg::GradW-1:0]  gx_s2, gy_s2;
	fcd_pkg::item_flags_t              flags_s2;
	logic [XW-1:0]                     x_s2, y_s2;

	fcd_sobel_window #(
		.XW(XW)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_s1(valid_s1),
		.older   (older_s1),
		.prev    (prev_s1),
		.newest  (cell_s1),
		.flags_s1(flags_s1),
		.x_s1    (x_s1),
		.y_s1    (y_s1),
		.valid_s2(valid_s2),
		.gx_s2   (gx_s2),
		.gy_s2   (gy_s2),
		.flags_s2(flags_s2),
		.x_s2    (x_s2),
		.y_s2    (y_s2)
	);

	// band test and numbering
	logic [fcd_pkg::GradW-1:0] abs_gx, abs_gy, grad_mag;
	logic                      in_band, hit;
	logic [fcd_pkg::NumW-1:0]  count_q, num_base;
	logic [OW-1:0]             res_word, out_q, skid_q;

	always_comb begin
		abs_gx   = gx_s2[fcd_pkg::GradW-1] ? fcd_pkg::GradW'(-gx_s2) : gx_s2;
		abs_gy   = gy_s2[fcd_pkg::GradW-1] ? fcd_pkg::GradW'(-gy_s2) : gy_s2;
		grad_mag = abs_gx + abs_gy;
		in_band  = (grad_mag >= fcd_pkg::GradW'(lower_threshold_q))
			&& (grad_mag <= fcd_pkg::GradW'(fcd_pkg::UpperLimit));
		hit      = valid_s2 && flags_s2.judge && in_band;
		num_base = flags_s2.grid_start ? '0 : count_q;
		res_word = {num_base,
			fcd_pkg::CoordW'(y_s2 - XW'(1)),
			fcd_pkg::CoordW'(x_s2 - XW'(1))};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en && valid_s2) begin
			count_q <= num_base + fcd_pkg::NumW'(hit);
		end
	end

	// output register with one skid word behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_axis_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (hit) begin
			if (!out_valid_q || m_axis_tready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_axis_tready) begin
				out_q <= skid_q;
			end
		end else if (hit) begin
			if (!out_valid_q || m_axis_tready) begin
				out_q <= res_word;
			end else begin
				skid_q <= res_word;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// a skid word is only ever held behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with empty output register");

	// position never leaves the line store
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(DW'(col_q) < DW'(MAX_GRID_DIM)) && (DW'(row_q) < DW'(MAX_GRID_DIM)))
		else $error("position counter past the largest grid");

	// frontier count steps by one or restarts at a grid start
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == fcd_pkg::NumW'($past(count_q) + fcd_pkg::NumW'(1)))
		|| (count_q == '0) || (count_q == fcd_pkg::NumW'(1)))
		else $error("frontier count jumped");

	// no word leaves the pipe while the skid word is held
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> (count_q == $past(count_q)))
		else $error("pipe advanced during stall");

endmodule

// File: hw/rtl/fcd_line_store.sv
module fcd_line_store #(
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic                     bank,
	input  logic [7:0]               wr_data,
	output logic [7:0]               older,
	output logic [7:0]               prev
);

	logic [7:0] bank0_mem [Depth];
	logic [7:0] bank1_mem [Depth];
	logic [7:0] rd0_s1;
	logic [7:0] rd1_s1;
	logic       sel_s1;

	// read-before-write: the bank being written still returns the row two rows back
	always_ff @(posedge clk) begin
		if (en) begin
			rd0_s1 <= bank0_mem[addr];
			rd1_s1 <= bank1_mem[addr];
			sel_s1 <= bank;
			if (!bank) begin
				bank0_mem[addr] <= wr_data;
			end else begin
				bank1_mem[addr] <= wr_data;
			end
		end
	end

	assign older = sel_s1 ? rd1_s1 : rd0_s1;
	assign prev  = sel_s1 ? rd0_s1 : rd1_s1;

endmodule

// File: hw/rtl/fcd_sobel_window.sv
module fcd_sobel_window #(
	parameter int XW = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid_s1,
	input  logic [7:0]                          older,
	input  logic [7:0]                          prev,
	input  logic [7:0]                          newest,
	input  fcd_pkg::item_flags_t                flags_s1,
	input  logic [XW-1:0]                       x_s1,
	input  logic [XW-1:0]                       y_s1,
	output logic                                valid_s2,
	output logic signed [fcd_pkg::GradW-1:0]    gx_s2,
	output logic signed [fcd_pkg::GradW-1:0]    gy_s2,
	output fcd_pkg::item_flags_t                flags_s2,
	output logic [XW-1:0]                       x_s2,
	output logic [XW-1:0]                       y_s2
);

	// two kept columns per row; row 0 is y-2, row 2 is y
	logic [7:0] mid_q  [3];  // column x-1
	logic [7:0] last_q [3];  // column x
	logic [7:0] col_in [3];

	logic [7:0] m_tl, m_t, m_tr, m_l, m_r, m_bl, m_b, m_br;
	logic [fcd_pkg::GradW-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
	logic center_unknown;

	always_comb begin
		col_in[0] = older;
		col_in[1] = prev;
		col_in[2] = newest;
		// window after the shift
		m_bl = fcd_pkg::cell_mag(mid_q[0]);
		m_b  = fcd_pkg::cell_mag(last_q[0]);
		m_br = fcd_pkg::cell_mag(older);
		m_l  = fcd_pkg::cell_mag(mid_q[1]);
		m_r  = fcd_pkg::cell_mag(prev);
		m_tl = fcd_pkg::cell_mag(mid_q[2]);
		m_t  = fcd_pkg::cell_mag(last_q[2]);
		m_tr = fcd_pkg::cell_mag(newest);
		center_unknown = (last_q[1] == fcd_pkg::CellUnknown);
		gx_pos = fcd_pkg::GradW'(m_tr) + fcd_pkg::GradW'(m_br)
			+ fcd_pkg::GradW'({m_r, 1'b0});
		gx_neg = fcd_pkg::GradW'(m_tl) + fcd_pkg::GradW'(m_bl)
			+ fcd_pkg::GradW'({m_l, 1'b0});
		gy_pos = fcd_pkg::GradW'(m_tl) + fcd_pkg::GradW'(m_tr)
			+ fcd_pkg::GradW'({m_t, 1'b0});
		gy_neg = fcd_pkg::GradW'(m_bl) + fcd_pkg::GradW'(m_br)
			+ fcd_pkg::GradW'({m_b, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				mid_q[r]  <= '0;
				last_q[r] <= '0;
			end
			valid_s2 <= 1'b0;
			flags_s2 <= '0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			flags_s2.grid_start <= flags_s1.grid_start;
			flags_s2.judge      <= flags_s1.judge && center_unknown;
			if (valid_s1) begin
				for (int r = 0; r < 3; r++) begin
					mid_q[r]  <= last_q[r];
					last_q[r] <= col_in[r];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s2 <= signed'(gx_pos - gx_neg);
			gy_s2 <= signed'(gy_pos - gy_neg);
			x_s2  <= x_s1;
			y_s2  <= y_s1;
		end
	end

endmodule
